// File: rtl/mmu_pkg.sv
package mmu_pkg;

    localparam int MAX_DIM_DEF      = 8;
    localparam int ELEMENT_BITS_DEF = 16;

    localparam int PRODUCT_W  = 35;
    localparam int OUT_IDX_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_reg_t;

    // 0 acts as 1, anything above the limit acts as the limit
    function automatic logic [CFG_DATA_W-1:0] clamp_dim(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CFG_DATA_W-1:0] max_v
    );
        logic [CFG_DATA_W-1:0] res;
        begin
            if (v == '0)
            begin
                res = CFG_DATA_W'(1);
            end
            else if (v > max_v)
            begin
                res = max_v;
            end
            else
            begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

// File: rtl/matrix_multiply_unit.sv
// Channel   Handshake                  Payload
// --------  -------------------------  ---------------------------------------------
// element   start, busy                element_value
// result    result_valid (strobe)      product_value, out_row, out_col, last_of_run
// config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// Loading takes one element per accepted start; busy stays low while A and B are loaded.
// The item that completes B raises busy; one MAC then steps over every r, c and k,
// one store read pair per cycle, and the last result passes the read, multiply and
// accumulate registers before it is strobed. busy falls at the end of that strobe;
// cfg_ready is low while busy. Reset sets the sizes to 8 and clears the load count;
// the stores are not cleared. Results are strobed for one cycle; the receiver cannot stall.
module matrix_multiply_unit #(
    parameter int MAX_DIM      = mmu_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_BITS = mmu_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ELEMENT_BITS-1:0]       element_value,
    output logic                                 result_valid,
    output logic signed [mmu_pkg::PRODUCT_W-1:0] product_value,
    output logic [mmu_pkg::OUT_IDX_W-1:0]        out_row,
    output logic [mmu_pkg::OUT_IDX_W-1:0]        out_col,
    output logic                                 last_of_run,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mmu_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mmu_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(2 * DEPTH + 1);
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int EXT_W  = (PROD_W > PRODUCT_W) ? PROD_W : PRODUCT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_el;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    logic signed [ELEMENT_BITS-1:0] a_store [DEPTH];
    logic signed [ELEMENT_BITS-1:0] b_store [DEPTH];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [CFG_DATA_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [IDX_W-1:0] r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [AW-1:0] a_base_reg, a_base_next, b_ptr_reg, b_ptr_next;

    logic s1_valid_reg, s2_valid_reg;
    tag_t s0_tag, s1_tag_reg, s2_tag_reg;
    logic signed [ELEMENT_BITS-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PRODUCT_W-1:0] acc_reg, acc_next;

    logic result_valid_reg;
    logic [PRODUCT_W-1:0] product_value_reg;
    logic [OUT_IDX_W-1:0] out_row_reg, out_col_reg;
    logic last_reg;

    logic [CFG_DATA_W-1:0] nr, nk, nc;
    logic [CNT_W-1:0] na, nb, total, b_index;
    logic accept, issue, a_we, b_we;
    logic [AW-1:0] a_wr_addr, b_wr_addr, a_rd_addr;
    logic last_r, last_c, last_k;
    logic signed [EXT_W-1:0] prod_ext;

    assign nr = clamp_dim(rows_reg, CFG_DATA_W'(MAX_DIM));
    assign nk = clamp_dim(inner_reg, CFG_DATA_W'(MAX_DIM));
    assign nc = clamp_dim(cols_reg, CFG_DATA_W'(MAX_DIM));
    assign na = CNT_W'(nr) * CNT_W'(nk);
    assign nb = CNT_W'(nk) * CNT_W'(nc);
    assign total = na + nb;

    assign accept    = start && (state_reg == ST_IDLE);
    assign b_index   = load_count_reg - na;
    assign a_we      = accept && (load_count_reg < na);
    assign b_we      = accept && (load_count_reg >= na) && (b_index < nb);
    assign a_wr_addr = load_count_reg[AW-1:0];
    assign b_wr_addr = b_index[AW-1:0];

    assign issue     = (state_reg == ST_RUN);
    assign a_rd_addr = a_base_reg + AW'(k_reg);
    assign last_r    = (CFG_DATA_W'(r_reg) + 1'b1) == nr;
    assign last_c    = (CFG_DATA_W'(c_reg) + 1'b1) == nc;
    assign last_k    = (CFG_DATA_W'(k_reg) + 1'b1) == nk;

    assign s0_tag.first   = (k_reg == '0);
    assign s0_tag.last_k  = last_k;
    assign s0_tag.last_el = last_r && last_c && last_k;
    assign s0_tag.row     = r_reg;
    assign s0_tag.col     = c_reg;

    assign prod_ext = EXT_W'(prod_reg);
    assign acc_next = (s2_tag_reg.first ? '0 : acc_reg) + prod_ext[PRODUCT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_store[a_wr_addr] <= element_value;
        end
        if (b_we)
        begin
            b_store[b_wr_addr] <= element_value;
        end
        a_rd_reg <= a_store[a_rd_addr];
        b_rd_reg <= b_store[b_ptr_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        a_base_next     = a_base_reg;
        b_ptr_next      = b_ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    load_count_next = load_count_reg + 1'b1;
                    if (load_count_next >= total)
                    begin
                        load_count_next = '0;
                        state_next      = ST_RUN;
                        r_next          = '0;
                        c_next          = '0;
                        k_next          = '0;
                        a_base_next     = '0;
                        b_ptr_next      = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (last_k)
                begin
                    k_next = '0;
                    if (last_c)
                    begin
                        c_next      = '0;
                        b_ptr_next  = '0;
                        r_next      = r_reg + 1'b1;
                        a_base_next = a_base_reg + AW'(nk);
                        if (last_r)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        b_ptr_next = AW'(c_reg) + 1'b1;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    b_ptr_next = b_ptr_reg + AW'(nc);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            load_count_reg   <= '0;
            rows_reg         <= DIM_RESET;
            inner_reg        <= DIM_RESET;
            cols_reg         <= DIM_RESET;
            r_reg            <= '0;
            c_reg            <= '0;
            k_reg            <= '0;
            a_base_reg       <= '0;
            b_ptr_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_count_reg   <= load_count_next;
            r_reg            <= r_next;
            c_reg            <= c_next;
            k_reg            <= k_next;
            a_base_reg       <= a_base_next;
            b_ptr_reg        <= b_ptr_next;
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg && s2_tag_reg.last_k;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROWS_A:    rows_reg  <= cfg_data;
                    CFG_INNER_DIM: inner_reg <= cfg_data;
                    CFG_COLS_B:    cols_reg  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // datapath: read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= s0_tag;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= a_rd_reg * b_rd_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (s2_valid_reg && s2_tag_reg.last_k)
        begin
            product_value_reg <= acc_next;
            out_row_reg       <= OUT_IDX_W'(s2_tag_reg.row);
            out_col_reg       <= OUT_IDX_W'(s2_tag_reg.col);
            last_reg          <= s2_tag_reg.last_el;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign product_value = product_value_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign last_of_run   = result_valid_reg && last_reg;

`ifndef SYNTHESIS
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_run |=> !result_valid)
        else $error("result after final element");

    a_run_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("run started without an item");
`endif

endmodule

// File: test/mmu_checker.sv
`timescale 1ns / 100ps

module mmu_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [mmu_pkg::ELEMENT_BITS_DEF-1:0] element_value,
    input  logic                                 result_valid,
    input  logic signed [mmu_pkg::PRODUCT_W-1:0] product_value,
    input  logic [mmu_pkg::OUT_IDX_W-1:0]        out_row,
    input  logic [mmu_pkg::OUT_IDX_W-1:0]        out_col,
    input  logic                                 last_of_run,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [mmu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mmu_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                   mismatch_count,
    output int                                   products_pending
);

    localparam int MAX_DIM   = mmu_pkg::MAX_DIM_DEF;
    localparam int ELEM_W    = mmu_pkg::ELEMENT_BITS_DEF;
    localparam int PRODUCT_W = mmu_pkg::PRODUCT_W;
    localparam int IDX_W     = mmu_pkg::OUT_IDX_W;
    localparam int DIM_W     = mmu_pkg::CFG_DATA_W;

    typedef struct {
        logic signed [PRODUCT_W-1:0] value;
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            col;
        logic                        is_last;
    } product_t;

    logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
    logic [7:0]               load_count;
    logic [DIM_W-1:0]         rows_cfg;
    logic [DIM_W-1:0]         inner_cfg;
    logic [DIM_W-1:0]         cols_cfg;
    product_t                 expected_products [$];

    initial
    begin
        mismatch_count = 0;
    end

    function automatic int dim_eff(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                   input logic signed [63:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic compute_products(input int nr, input int nk, input int nc);
        longint   acc;
        product_t p;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                acc = 0;
                for (int k = 0; k < nk; k++)
                begin
                    acc += longint'(a_mem[r*nk + k]) * longint'(b_mem[k*nc + c]);
                end
                p.value   = acc[PRODUCT_W-1:0];
                p.row     = r[IDX_W-1:0];
                p.col     = c[IDX_W-1:0];
                p.is_last = (r == nr - 1) && (c == nc - 1);
                expected_products.push_back(p);
            end
        end
    endtask

    task automatic take_element(input logic signed [ELEM_W-1:0] v);
        int nr;
        int nk;
        int nc;
        int na;
        int nb;
        int lc;
        nr = dim_eff(rows_cfg);
        nk = dim_eff(inner_cfg);
        nc = dim_eff(cols_cfg);
        na = nr * nk;
        nb = nk * nc;
        lc = int'(load_count);
        if (lc < na)
        begin
            a_mem[lc] = v;
        end
        else if (lc - na < nb)
        begin
            b_mem[lc - na] = v;
        end
        // a shrink while loading may leave the count past the new total
        load_count = load_count + 8'd1;
        if (int'(load_count) >= na + nb)
        begin
            load_count = '0;
            compute_products(nr, nk, nc);
        end
    endtask

    task automatic check_product();
        product_t want;
        if (expected_products.size() == 0)
        begin
            report_mismatch("result with none outstanding", product_value, 0);
            return;
        end
        want = expected_products.pop_front();
        if (product_value !== want.value)
        begin
            report_mismatch("product_value", product_value, want.value);
        end
        if (out_row !== want.row)
        begin
            report_mismatch("out_row", {61'd0, out_row}, {61'd0, want.row});
        end
        if (out_col !== want.col)
        begin
            report_mismatch("out_col", {61'd0, out_col}, {61'd0, want.col});
        end
        if (last_of_run !== want.is_last)
        begin
            report_mismatch("last_of_run", {63'd0, last_of_run}, {63'd0, want.is_last});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count = '0;
            rows_cfg   = mmu_pkg::DIM_RESET;
            inner_cfg  = mmu_pkg::DIM_RESET;
            cols_cfg   = mmu_pkg::DIM_RESET;
            expected_products.delete();
            products_pending <= 0;
        end
        else
        begin
            if (result_valid === 1'b1)
            begin
                check_product();
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mmu_pkg::CFG_ROWS_A:    rows_cfg  = cfg_data;
                    mmu_pkg::CFG_INNER_DIM: inner_cfg = cfg_data;
                    mmu_pkg::CFG_COLS_B:    cols_cfg  = cfg_data;
                    default:                ;
                endcase
            end
            if (start && !busy)
            begin
                take_element(element_value);
            end
            products_pending <= expected_products.size();
        end
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 310;
    localparam int DIM_W       = mmu_pkg::CFG_DATA_W;

    logic                                        clk;
    logic                                        rst_n;
    logic                                        start;
    logic                                        busy;
    logic signed [mmu_pkg::ELEMENT_BITS_DEF-1:0] element_value;
    logic                                        result_valid;
    logic signed [mmu_pkg::PRODUCT_W-1:0]        product_value;
    logic [mmu_pkg::OUT_IDX_W-1:0]               out_row;
    logic [mmu_pkg::OUT_IDX_W-1:0]               out_col;
    logic                                        last_of_run;
    logic                                        cfg_valid;
    logic                                        cfg_ready;
    logic [mmu_pkg::CFG_IDX_W-1:0]               cfg_index;
    logic [DIM_W-1:0]                            cfg_data;
    int                                          mismatch_count;
    int                                          products_pending;

    int cycle_count = 0;
    int items_sent;
    int dim_r;
    int dim_k;
    int dim_c;
    bit no_gaps;

    logic signed [15:0] directed_vals [24] = '{
        -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd1, 16'sd32767,
        -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd256, -16'sd256, 16'sh5555,
        -16'sd32768,
        16'sd32767,
        -16'sd32768, 16'sd32767, -16'sd1, 16'sd0, 16'shAAAA, 16'sd255, -16'sd255, 16'sd1
    };

    matrix_multiply_unit DUT (.*);

    mmu_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [15:0] pick_element(input bit extremes);
        logic [31:0] r;
        if (extremes || $urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return -16'sd32768;
                1:       return 16'sd32767;
                2:       return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        r = $urandom();
        return r[15:0];
    endfunction

    // coding 0: plain, 1: 1 as 0 and 8 as 15, 2: 1 as 0 and 8 as 9..15
    function automatic logic [DIM_W-1:0] dim_code(input int e, input int coding);
        if (coding != 0 && e == 1)
        begin
            return '0;
        end
        if (coding == 1 && e == 8)
        begin
            return 4'd15;
        end
        if (coding == 2 && e == 8)
        begin
            return DIM_W'($urandom_range(9, 15));
        end
        return DIM_W'(e);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 90)
        begin
            return $urandom_range(4, 6);
        end
        return $urandom_range(7, 8);
    endfunction

    task automatic write_reg(input mmu_pkg::cfg_reg_t idx, input logic [DIM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    task automatic set_dims(input int r, input int k, input int c, input int coding);
        dim_r = r;
        dim_k = k;
        dim_c = c;
        write_reg(mmu_pkg::CFG_ROWS_A, dim_code(r, coding));
        write_reg(mmu_pkg::CFG_INNER_DIM, dim_code(k, coding));
        write_reg(mmu_pkg::CFG_COLS_B, dim_code(c, coding));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_element(input logic signed [15:0] v);
        start         <= 1'b1;
        element_value <= v;
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic pause();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
        begin
            return;
        end
        if (r < 85)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            gap = $urandom_range(4, 12);
        end
        else
        begin
            gap = $urandom_range(20, 40);
        end
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // capped by what is left of the item budget
    task automatic stream(input int n, input bit extremes);
        int count;
        count = (n < ITEM_TARGET - items_sent) ? n : ITEM_TARGET - items_sent;
        for (int i = 0; i < count; i++)
        begin
            send_element(pick_element(extremes));
            if (i < count - 1)
            begin
                pause();
            end
        end
    endtask

    task automatic send_directed(input int lo, input int hi);
        for (int i = lo; i <= hi; i++)
        begin
            send_element(directed_vals[i]);
            if (i < hi)
            begin
                pause();
            end
        end
    endtask

    // drop start, drain every product, then let busy fall
    task automatic settle(input int tail);
        start <= 1'b0;
        do @(posedge clk); while (products_pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic plain_run();
        int per_matrix;
        set_dims(pick_dim(), pick_dim(), pick_dim(), ($urandom_range(0, 3) == 0) ? 2 : 0);
        per_matrix = dim_r * dim_k + dim_k * dim_c;
        stream(per_matrix * $urandom_range(1, 3), $urandom_range(0, 4) == 0);
        settle(4);
    endtask

    // sizes change partway through a load; all store entries are written by now
    task automatic split_run();
        int loaded;
        int rest;
        set_dims(pick_dim(), pick_dim(), pick_dim(), 0);
        loaded = $urandom_range(1, dim_r * dim_k + dim_k * dim_c - 1);
        stream(loaded, 1'b0);
        settle(4);
        set_dims(pick_dim(), pick_dim(), pick_dim(), ($urandom_range(0, 3) == 0) ? 2 : 0);
        rest = dim_r * dim_k + dim_k * dim_c - loaded;
        stream((rest < 1) ? 1 : rest, 1'b0);
        settle(4);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        element_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = mmu_pkg::CFG_ROWS_A;
        cfg_data      = '0;
        items_sent    = 0;
        no_gaps       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        set_dims(1, 1, 1, 1);
        send_directed(0, 5);
        settle(4);
        set_dims(8, 1, 1, 1);
        send_directed(6, 14);
        settle(4);
        set_dims(1, 1, 8, 2);
        send_directed(15, 23);
        settle(4);

        set_dims(8, 8, 8, 0);
        stream(128, 1'b0);
        settle(4);

        while (items_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                split_run();
            end
            else
            begin
                plain_run();
            end
        end

        settle(8);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
